### design/asea_pkg.sv
// Package: types, constants and microcode ROM for the analog scale / EMA / alarm block.
package asea_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RAW_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENG_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENG_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LOW  = 3'd6;

  localparam logic signed [15:0] ALARM_OFF_CODE = 16'sh8000;
  localparam logic [6:0]         FILT_DIV       = 7'd101;
  localparam logic [6:0]         FILT_MAX       = 7'd100;

  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_ITER  = DIV_NUM_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER + 1);

  localparam int unsigned UC_DEPTH = 16;
  localparam int unsigned PC_W     = $clog2(UC_DEPTH);

  typedef enum logic [3:0] {
    OP_FETCH,
    OP_SETUP_SCALE,
    OP_MUL,
    OP_DIV_SCALE,
    OP_DIV_FILT,
    OP_DIV_WAIT,
    OP_SCALE,
    OP_CLAMP,
    OP_EMPTY,
    OP_PRIME,
    OP_SETUP_FILT,
    OP_FILT_UPD,
    OP_ROUND,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_EMPTY,
    C_DIV_BUSY,
    C_SMOOTH_OFF,
    C_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0:  w = '{op: OP_FETCH,       cond: C_NO_INPUT,    target: 4'd0};
      4'd1:  w = '{op: OP_SETUP_SCALE, cond: C_EMPTY,       target: 4'd7};
      4'd2:  w = '{op: OP_MUL,         cond: C_NEXT,        target: 4'd0};
      4'd3:  w = '{op: OP_DIV_SCALE,   cond: C_NEXT,        target: 4'd0};
      4'd4:  w = '{op: OP_DIV_WAIT,    cond: C_DIV_BUSY,    target: 4'd4};
      4'd5:  w = '{op: OP_SCALE,       cond: C_NEXT,        target: 4'd0};
      4'd6:  w = '{op: OP_CLAMP,       cond: C_ALWAYS,      target: 4'd8};
      4'd7:  w = '{op: OP_EMPTY,       cond: C_NEXT,        target: 4'd0};
      4'd8:  w = '{op: OP_PRIME,       cond: C_SMOOTH_OFF,  target: 4'd14};
      4'd9:  w = '{op: OP_SETUP_FILT,  cond: C_NEXT,        target: 4'd0};
      4'd10: w = '{op: OP_MUL,         cond: C_NEXT,        target: 4'd0};
      4'd11: w = '{op: OP_DIV_FILT,    cond: C_NEXT,        target: 4'd0};
      4'd12: w = '{op: OP_DIV_WAIT,    cond: C_DIV_BUSY,    target: 4'd12};
      4'd13: w = '{op: OP_FILT_UPD,    cond: C_NEXT,        target: 4'd0};
      4'd14: w = '{op: OP_ROUND,       cond: C_NEXT,        target: 4'd0};
      4'd15: w = '{op: OP_OUT,         cond: C_OUT_BLOCKED, target: 4'd15};
      default: w = '{op: OP_FETCH,     cond: C_ALWAYS,      target: 4'd0};
    endcase
    return w;
  endfunction

endpackage

### design/asea_div.sv
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
module asea_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [asea_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [asea_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           busy_o,
  output logic [asea_pkg::DIV_NUM_W-1:0] quot_o
);
  import asea_pkg::*;

  logic [DIV_NUM_W-1:0] work_q, work_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;

  always_comb begin
    logic [DIV_DEN_W:0]   r;
    logic [DIV_NUM_W-1:0] w;
    logic [DIV_DEN_W-1:0] rm;
    w  = work_q;
    rm = rem_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r = {rm, w[DIV_NUM_W-1]};
      w = {w[DIV_NUM_W-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r    = r - {1'b0, den_q};
        w[0] = 1'b1;
      end
      rm = r[DIV_DEN_W-1:0];
    end
    work_d = w;
    rem_d  = rm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DIV_ITER);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = work_q;

  start_when_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

  count_tracks_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0)) else $error("divider busy with zero count");

  finish_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == DIV_CNT_W'(1) && !start_i) |=> !busy_q)
    else $error("divider did not finish on last step");

endmodule

### design/analog_scale_ema_alarm.sv
// Top level: microcoded scale, clamp, EMA filter, rounding and alarms for one analog channel.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid_i/in_ready_o | sample_i
//  out     | out_valid_o/out_ready_i | eng_value_o, high_alarm_o, low_alarm_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One sample at a time: a new sample is accepted only at the fetch step.
//  Empty range: the scale pass is skipped and the low engineering value is used.
//  The shared radix-4 divider serves both passes (scale, filter).
//  Reset restores the register defaults and clears the filter state; no clearing pass.
//  A result waiting in the output register stalls the sequencer only at its output step.
//  Configuration writes are always taken.
module analog_scale_ema_alarm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [15:0]                    sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             eng_value_o,
  output logic                           high_alarm_o,
  output logic                           low_alarm_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [asea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asea_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import asea_pkg::*;

  // configuration
  logic [15:0]        raw_low_q, raw_high_q;
  logic signed [15:0] eng_low_q, eng_high_q;
  logic [6:0]         smoothing_q;
  logic signed [15:0] alarm_high_q, alarm_low_q;

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uc;

  // datapath
  logic [15:0]           sample_q;
  logic [31:0]           mul_a_q;
  logic [15:0]           mul_b_q;
  logic [47:0]           prod_q;
  logic                  neg_q;
  logic [DIV_DEN_W-1:0]  den_q;
  logic signed [49:0]    acc_q;
  logic signed [31:0]    y_q;
  logic signed [31:0]    fv_q;
  logic                  primed_q;
  logic signed [15:0]    eng_q;

  // output register
  logic                  out_valid_q;
  logic signed [15:0]    out_eng_q;
  logic                  out_hi_q, out_lo_q;

  // divider
  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic                  div_busy;
  logic [DIV_NUM_W-1:0]  div_quot;

  // combinational helpers
  logic signed [16:0] dsig, span, espan, dabs, sabs, eabs;
  logic               empty_c;
  logic signed [32:0] diff, diff_abs;
  logic [6:0]         fsat, wgt;
  logic signed [49:0] q_ext, q_sgn, base_ext, lo_ext, hi_ext;
  logic signed [33:0] upd;
  logic [32:0]        rpos, rneg_mag;
  logic [15:0]        eng_c;
  logic               in_fire, out_blocked, hi_c, lo_c;

  assign uc          = ucode_rom(pc_q);
  assign in_ready_o  = (uc.op == OP_FETCH);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_blocked = out_valid_q && !out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    dsig  = $signed({1'b0, sample_q}) - $signed({1'b0, raw_low_q});
    span  = $signed({1'b0, raw_high_q}) - $signed({1'b0, raw_low_q});
    espan = $signed({eng_high_q[15], eng_high_q}) - $signed({eng_low_q[15], eng_low_q});
    dabs  = dsig[16]  ? -dsig  : dsig;
    sabs  = span[16]  ? -span  : span;
    eabs  = espan[16] ? -espan : espan;
    empty_c = (span == 17'sd0) || (espan == 17'sd0);

    diff     = $signed({y_q[31], y_q}) - $signed({fv_q[31], fv_q});
    diff_abs = diff[32] ? -diff : diff;
    fsat     = (smoothing_q > FILT_MAX) ? FILT_MAX : smoothing_q;
    wgt      = FILT_DIV - fsat;

    q_ext    = $signed({2'b00, div_quot});
    q_sgn    = neg_q ? -q_ext : q_ext;
    base_ext = $signed({{18{eng_low_q[15]}}, eng_low_q, 16'h0000});
    hi_ext   = $signed({{18{eng_high_q[15]}}, eng_high_q, 16'h0000});
    lo_ext   = base_ext;
    if (eng_low_q >= eng_high_q) begin
      lo_ext = hi_ext;
      hi_ext = base_ext;
    end

    upd = $signed({{2{fv_q[31]}}, fv_q})
        + (neg_q ? -$signed({2'b00, div_quot[31:0]}) : $signed({2'b00, div_quot[31:0]}));

    rpos     = {1'b0, y_q} + 33'd32768;
    rneg_mag = (-{y_q[31], y_q}) + 33'd32768;
    eng_c    = y_q[31] ? -rneg_mag[31:16] : rpos[31:16];

    hi_c = (alarm_high_q != ALARM_OFF_CODE) && (eng_q >= alarm_high_q);
    lo_c = (alarm_low_q  != ALARM_OFF_CODE) && (eng_q <= alarm_low_q);
  end

  // sequencer
  always_comb begin
    logic jump;
    case (uc.cond)
      C_NEXT:        jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_INPUT:    jump = !in_fire;
      C_EMPTY:       jump = empty_c;
      C_DIV_BUSY:    jump = div_busy;
      C_SMOOTH_OFF:  jump = (smoothing_q == 7'd0);
      C_OUT_BLOCKED: jump = out_blocked;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? uc.target : PC_W'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  // divider operands
  assign div_start = (uc.op == OP_DIV_SCALE) || (uc.op == OP_DIV_FILT);
  always_comb begin
    if (uc.op == OP_DIV_SCALE) begin
      div_num = {prod_q[31:0], 16'h0000} + DIV_NUM_W'(den_q >> 1);
    end else begin
      div_num = prod_q + DIV_NUM_W'(den_q >> 1);
    end
  end

  asea_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // datapath payload
  always_ff @(posedge clk_i) begin
    case (uc.op)
      OP_FETCH: begin
        if (in_fire) begin
          sample_q <= sample_i;
        end
      end
      OP_SETUP_SCALE: begin
        mul_a_q <= {16'h0000, dabs[15:0]};
        mul_b_q <= eabs[15:0];
        neg_q   <= dsig[16] ^ espan[16] ^ span[16];
        den_q   <= sabs[15:0];
      end
      OP_MUL:      prod_q <= mul_a_q * mul_b_q;
      OP_SCALE:    acc_q  <= base_ext + q_sgn;
      OP_CLAMP: begin
        if (acc_q < lo_ext) begin
          y_q <= lo_ext[31:0];
        end else if (acc_q > hi_ext) begin
          y_q <= hi_ext[31:0];
        end else begin
          y_q <= acc_q[31:0];
        end
      end
      OP_EMPTY:    y_q <= base_ext[31:0];
      OP_SETUP_FILT: begin
        mul_a_q <= diff_abs[31:0];
        mul_b_q <= {9'h000, wgt};
        neg_q   <= diff[32];
        den_q   <= {9'h000, FILT_DIV};
      end
      OP_FILT_UPD: y_q   <= upd[31:0];
      OP_ROUND:    eng_q <= eng_c;
      default: ;
    endcase
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q     <= '0;
      primed_q <= 1'b0;
    end else if (uc.op == OP_PRIME && smoothing_q != 7'd0 && !primed_q) begin
      fv_q     <= y_q;
      primed_q <= 1'b1;
    end else if (uc.op == OP_FILT_UPD) begin
      fv_q <= upd[31:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uc.op == OP_OUT && !out_blocked) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.op == OP_OUT && !out_blocked) begin
      out_eng_q <= eng_q;
      out_hi_q  <= hi_c;
      out_lo_q  <= lo_c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign eng_value_o  = out_eng_q;
  assign high_alarm_o = out_hi_q;
  assign low_alarm_o  = out_lo_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_low_q    <= 16'd0;
      raw_high_q   <= 16'hFFFF;
      eng_low_q    <= 16'sd0;
      eng_high_q   <= 16'sd10000;
      smoothing_q  <= 7'd0;
      alarm_high_q <= ALARM_OFF_CODE;
      alarm_low_q  <= ALARM_OFF_CODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RAW_LOW:    raw_low_q    <= cfg_data_i;
        CFG_RAW_HIGH:   raw_high_q   <= cfg_data_i;
        CFG_ENG_LOW:    eng_low_q    <= $signed(cfg_data_i);
        CFG_ENG_HIGH:   eng_high_q   <= $signed(cfg_data_i);
        CFG_SMOOTHING:  smoothing_q  <= cfg_data_i[6:0];
        CFG_ALARM_HIGH: alarm_high_q <= $signed(cfg_data_i);
        CFG_ALARM_LOW:  alarm_low_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  primed_sticky_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(primed_q)) else $error("filter lost its primed state");

  div_start_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");

  out_write_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.op == OP_OUT && !out_blocked) |=> (out_valid_q && pc_q == '0))
    else $error("result write did not complete");

  wait_holds_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.op == OP_DIV_WAIT && div_busy) |=> $stable(pc_q))
    else $error("sequencer left divider wait early");

endmodule
